### hw/rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own behavior.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define LR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/lr_pkg.sv
// Line rasterizer package: field widths, draw mode codes and the structs
// passed between controller and datapath. No dependencies.
`default_nettype none

package lr_pkg;

	localparam int COORD_W = 6;
	localparam int WORD_W  = 8;
	localparam int BIT_W   = 4;
	localparam int MODE_W  = 2;
	localparam int ERR_W   = 8;

	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INVERT = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
		logic [MODE_W-1:0]  draw_mode;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] pixel_x;
		logic [COORD_W-1:0] pixel_y;
		logic [WORD_W-1:0]  word_index;
		logic [BIT_W-1:0]   bit_index;
		logic [MODE_W-1:0]  pixel_mode;
		logic               visible;
		logic               last_pixel;
	} pix_t;

	typedef struct packed {
		logic load;
		logic step;
	} ctrl_t;

	typedef struct packed {
		logic at_end;
	} stat_t;

endpackage

`default_nettype wire

### hw/rtl/lr_cmd_if.sv
// Line command channel: valid/ready handshake with the two endpoints and mode.
// Depends on lr_pkg for field widths.
`default_nettype none

interface lr_cmd_if;
	logic                       valid;
	logic                       ready;
	logic [lr_pkg::COORD_W-1:0] start_x;
	logic [lr_pkg::COORD_W-1:0] start_y;
	logic [lr_pkg::COORD_W-1:0] end_x;
	logic [lr_pkg::COORD_W-1:0] end_y;
	logic [lr_pkg::MODE_W-1:0]  draw_mode;

	modport source (output valid, start_x, start_y, end_x, end_y, draw_mode, input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, draw_mode, output ready);
endinterface

`default_nettype wire

### hw/rtl/lr_pix_if.sv
// Pixel-write channel: valid/ready handshake with one pixel transaction.
// Depends on lr_pkg for field widths.
`default_nettype none

interface lr_pix_if;
	logic                       valid;
	logic                       ready;
	logic [lr_pkg::COORD_W-1:0] pixel_x;
	logic [lr_pkg::COORD_W-1:0] pixel_y;
	logic [lr_pkg::WORD_W-1:0]  word_index;
	logic [lr_pkg::BIT_W-1:0]   bit_index;
	logic [lr_pkg::MODE_W-1:0]  pixel_mode;
	logic                       visible;
	logic                       last_pixel;

	modport source (output valid, pixel_x, pixel_y, word_index, bit_index, pixel_mode,
		visible, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, word_index, bit_index, pixel_mode,
		visible, last_pixel, output ready);
endinterface

`default_nettype wire

### hw/rtl/lr_ctrl.sv
// Line rasterizer controller: idle/run state machine and output valid flag.
// Depends on lr_pkg for the command and status structs.
`default_nettype none

module lr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	output logic               pix_valid,
	input  wire logic          pix_ready,
	output lr_pkg::ctrl_t      ctrl,
	input  wire lr_pkg::stat_t stat
);

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t state_q;
	logic   pix_valid_q;
	logic   out_free;

	assign cmd_ready = (state_q == S_IDLE);
	assign pix_valid = pix_valid_q;
	assign out_free  = !pix_valid_q || pix_ready;
	assign ctrl.load = cmd_valid && cmd_ready;
	assign ctrl.step = (state_q == S_RUN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pix_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.load) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (ctrl.step && stat.at_end) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctrl.step) begin
				pix_valid_q <= 1'b1;
			end else if (pix_ready) begin
				pix_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/lr_dpath.sv
// Line rasterizer datapath: line setup, Bresenham stepping registers and the
// pixel output register with framebuffer address. Depends on lr_pkg.
`default_nettype none

module lr_dpath #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 48
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lr_pkg::ctrl_t ctrl,
	output lr_pkg::stat_t      stat,
	input  wire lr_pkg::cmd_t  cmd,
	output lr_pkg::pix_t       pix
);

	localparam int HALF_W = SCREEN_WIDTH / 2;
	localparam int CW     = lr_pkg::COORD_W;
	localparam int EW     = lr_pkg::ERR_W;

	logic [CW-1:0]             major_pos_q, major_end_q, minor_pos_q;
	logic [CW-1:0]             major_delta_q, minor_delta_q;
	logic signed [EW-1:0]      err_q;
	logic                      step_down_q, swapped_q;
	logic [lr_pkg::MODE_W-1:0] mode_q;
	lr_pkg::pix_t              pix_q;

	logic [CW-1:0]        adx, ady, a_maj, a_min, b_maj, b_min, min_d;
	logic                 steep;
	logic signed [EW-1:0] err_sub;
	logic [CW-1:0]        px, py;
	logic                 mode_ok, on_screen, writes;
	logic [lr_pkg::WORD_W-1:0] word;

	always_comb begin
		adx   = (cmd.start_x > cmd.end_x) ? cmd.start_x - cmd.end_x : cmd.end_x - cmd.start_x;
		ady   = (cmd.start_y > cmd.end_y) ? cmd.start_y - cmd.end_y : cmd.end_y - cmd.start_y;
		steep = (ady > adx);
		if (steep) begin
			a_maj = cmd.start_y;
			a_min = cmd.start_x;
			b_maj = cmd.end_y;
			b_min = cmd.end_x;
		end else begin
			a_maj = cmd.start_x;
			a_min = cmd.start_y;
			b_maj = cmd.end_x;
			b_min = cmd.end_y;
		end
		if (a_maj > b_maj) begin
			{a_maj, b_maj} = {b_maj, a_maj};
			{a_min, b_min} = {b_min, a_min};
		end
		min_d = (a_min > b_min) ? a_min - b_min : b_min - a_min;
	end

	assign err_sub = err_q - $signed({{(EW-CW){1'b0}}, minor_delta_q});

	assign px        = swapped_q ? minor_pos_q : major_pos_q;
	assign py        = swapped_q ? major_pos_q : minor_pos_q;
	assign mode_ok   = (mode_q <= lr_pkg::MODE_INVERT);
	assign on_screen = ({1'b0, px} < (CW+1)'(SCREEN_WIDTH))
		&& ({1'b0, py} < (CW+1)'(SCREEN_HEIGHT));
	assign writes    = on_screen && mode_ok;
	assign word      = lr_pkg::WORD_W'(px >> 1)
		+ lr_pkg::WORD_W'(lr_pkg::WORD_W'(py >> 3) * lr_pkg::WORD_W'(HALF_W));

	assign stat.at_end = (major_pos_q == major_end_q);
	assign pix         = pix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q   <= '0;
			major_end_q   <= '0;
			minor_pos_q   <= '0;
			major_delta_q <= '0;
			minor_delta_q <= '0;
			err_q         <= '0;
			step_down_q   <= 1'b0;
			swapped_q     <= 1'b0;
			mode_q        <= '0;
		end else if (ctrl.load) begin
			major_pos_q   <= a_maj;
			major_end_q   <= b_maj;
			minor_pos_q   <= a_min;
			major_delta_q <= b_maj - a_maj;
			minor_delta_q <= min_d;
			err_q         <= $signed(EW'((b_maj - a_maj) >> 1));
			step_down_q   <= !(a_min < b_min);
			swapped_q     <= steep;
			mode_q        <= cmd.draw_mode;
		end else if (ctrl.step) begin
			major_pos_q <= major_pos_q + 1'b1;
			if (err_sub < 0) begin
				minor_pos_q <= step_down_q ? minor_pos_q - 1'b1 : minor_pos_q + 1'b1;
				err_q       <= err_sub + $signed({{(EW-CW){1'b0}}, major_delta_q});
			end else begin
				err_q <= err_sub;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			pix_q.pixel_x    <= px;
			pix_q.pixel_y    <= py;
			pix_q.word_index <= writes ? word : '0;
			pix_q.bit_index  <= {px[0], py[2:0]};
			pix_q.pixel_mode <= mode_ok ? mode_q : lr_pkg::MODE_CLEAR;
			pix_q.visible    <= writes;
			pix_q.last_pixel <= stat.at_end;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/line_rasterizer.sv
// Line rasterizer top level: joins lr_ctrl and lr_dpath to the command and pixel channels.
// Pixels are registered: an accepted command moves the state machine to run, and each step
// loads the pixel output register. Throughput: one pixel per cycle while pix.ready is high;
// N = major-axis span + 1 pixels per line (at most 64), all stepped before a new command.
// Reset: arst_n clears the state machine, output valid and stepping state at once.
`default_nettype none
`include "assert_macros.svh"

module line_rasterizer #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	lr_cmd_if.sink   cmd,
	lr_pix_if.source pix
);

	lr_pkg::ctrl_t ctrl;
	lr_pkg::stat_t stat;
	lr_pkg::cmd_t  cmd_data;
	lr_pkg::pix_t  pix_data;

	assign cmd_data.start_x   = cmd.start_x;
	assign cmd_data.start_y   = cmd.start_y;
	assign cmd_data.end_x     = cmd.end_x;
	assign cmd_data.end_y     = cmd.end_y;
	assign cmd_data.draw_mode = cmd.draw_mode;

	assign pix.pixel_x    = pix_data.pixel_x;
	assign pix.pixel_y    = pix_data.pixel_y;
	assign pix.word_index = pix_data.word_index;
	assign pix.bit_index  = pix_data.bit_index;
	assign pix.pixel_mode = pix_data.pixel_mode;
	assign pix.visible    = pix_data.visible;
	assign pix.last_pixel = pix_data.last_pixel;

	lr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	lr_dpath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.cmd    (cmd_data),
		.pix    (pix_data)
	);

	`LR_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready)
	`LR_ASSERT_NOW(a_hidden_no_word, pix.valid && !pix.visible, pix.word_index == 8'd0)
	`LR_ASSERT_NOW(a_visible_mode_ok, pix.valid && pix.visible, pix.pixel_mode <= lr_pkg::MODE_INVERT)

endmodule

`default_nettype wire
